### sv/ipu_pkg.sv
// Shared types and constants for the in-place partition block.
package ipu_pkg;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int SPLIT_W   = 7;
  localparam int COORD_W   = 16;
  localparam int PIVOT_W   = 6;

  // Register index, taken from paddr[2]
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_PIVOT = 1'b1;

  // Operation codes held in the mode register
  localparam logic MODE_PARTITION = 1'b0;
  localparam logic MODE_UNDO      = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [PIVOT_W-1:0] pivot_index;
  } cfg_t;

endpackage

### sv/ipu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ipu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ipu_cfg.sv
// APB-style register file for mode and pivot index.
module ipu_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipu_pkg::PADDR_W-1:0] paddr,
  input  logic [ipu_pkg::PDATA_W-1:0] pwdata,
  output logic [ipu_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output ipu_pkg::cfg_t               cfg
);

  logic                        mode_r;
  logic [ipu_pkg::PIVOT_W-1:0] pivot_r;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ipu_pkg::MODE_PARTITION;
      pivot_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        ipu_pkg::REG_MODE:  mode_r  <= pwdata[0];
        ipu_pkg::REG_PIVOT: pivot_r <= pwdata[ipu_pkg::PIVOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ipu_pkg::REG_MODE:  prdata = ipu_pkg::PDATA_W'(mode_r);
      ipu_pkg::REG_PIVOT: prdata = ipu_pkg::PDATA_W'(pivot_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.mode        = mode_r;
  assign cfg.pivot_index = pivot_r;

endmodule

### sv/ipu_core.sv
// Load, scan sequencer and emit logic around the point store.
module ipu_core #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ipu_pkg::cfg_t                      cfg,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ipu_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [ipu_pkg::COORD_W-1:0] in_y_coord,
  input  logic        [ipu_pkg::SPLIT_W-1:0] in_split_in,
  input  logic                               in_last_in,
  output logic                               out_valid,
  output logic signed [ipu_pkg::COORD_W-1:0] out_x_out,
  output logic signed [ipu_pkg::COORD_W-1:0] out_y_out,
  output logic        [ipu_pkg::SPLIT_W-1:0] out_split_out,
  output logic                               out_last_out
);

  localparam int KEY_BITS = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int ENT_W    = 2 * KEY_BITS;
  localparam int ADDR_W   = $clog2(MAX_POINTS);
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int SW       = ipu_pkg::SPLIT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PV0  = 4'd1;
  localparam logic [3:0] S_PV1  = 4'd2;
  localparam logic [3:0] S_PV2  = 4'd3;
  localparam logic [3:0] S_PV3  = 4'd4;
  localparam logic [3:0] S_LOOP = 4'd5;
  localparam logic [3:0] S_RA   = 4'd6;
  localparam logic [3:0] S_RC   = 4'd7;
  localparam logic [3:0] S_RB   = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_W1   = 4'd10;
  localparam logic [3:0] S_W2   = 4'd11;
  localparam logic [3:0] S_W3   = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] h_r, h_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] e_r, e_nxt;
  logic [SW-1:0]    split_r, split_nxt;
  logic             mode_r, mode_nxt;
  logic             emit_vld_r, emit_vld_nxt;
  logic             emit_last_r, emit_last_nxt;
  logic [ENT_W-1:0] a_r, a_nxt;
  logic [ENT_W-1:0] b_r, b_nxt;
  logic [ENT_W-1:0] c_r, c_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic             accept, room, hit, pv_swap;
  logic [CNT_W-1:0] n_val, n_m1, hm1;
  logic [SW-1:0]    h_split;
  logic [CNT_W-1:0] pivot_w;
  logic signed [KEY_BITS-1:0] ax, ay, cx, cy, ox, oy;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign room   = (cnt_r < CNT_W'(MAX_POINTS));
  assign n_val  = room ? cnt_r + 1'b1 : cnt_r;
  assign n_m1   = n_val - 1'b1;
  assign hm1    = h_r - 1'b1;
  assign h_split = (in_split_in == '0) ? '0 : in_split_in - 1'b1;

  // Pivot swap only when the index names a loaded slot other than slot 0
  assign pivot_w = CNT_W'(cfg.pivot_index);
  assign pv_swap = ({1'b0, cfg.pivot_index} < (ipu_pkg::PIVOT_W + 1)'(n_r)) &&
                   (cfg.pivot_index != '0);

  assign ax = a_r[ENT_W-1:KEY_BITS];
  assign ay = a_r[KEY_BITS-1:0];
  assign cx = c_r[ENT_W-1:KEY_BITS];
  assign cy = c_r[KEY_BITS-1:0];
  assign hit = (mode_r == ipu_pkg::MODE_PARTITION) ? (cx < ax) : (ay > cy);

  ipu_ram #(.WIDTH(ENT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    split_nxt     = split_r;
    mode_nxt      = mode_r;
    emit_vld_nxt  = 1'b0;
    emit_last_nxt = emit_last_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_wdata     = {in_x_coord[KEY_BITS-1:0], in_y_coord[KEY_BITS-1:0]};
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // store the beat unless the set is already full
          ram_we  = room;
          cnt_nxt = n_val;
          if (in_last_in) begin
            n_nxt    = n_val;
            cnt_nxt  = '0;
            mode_nxt = cfg.mode;
            if (cfg.mode == ipu_pkg::MODE_PARTITION) begin
              h_nxt     = CNT_W'(1);
              k_nxt     = CNT_W'(1);
              state_nxt = S_PV0;
            end else begin
              h_nxt     = (h_split > SW'(n_m1)) ? n_m1 : CNT_W'(h_split);
              k_nxt     = n_m1;
              state_nxt = S_LOOP;
            end
          end
        end
      end
      S_PV0: begin
        ram_raddr = '0;
        state_nxt = pv_swap ? S_PV1 : S_LOOP;
      end
      S_PV1: begin
        ram_raddr = pivot_w[ADDR_W-1:0];
        a_nxt     = ram_rdata;
        state_nxt = S_PV2;
      end
      S_PV2: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        state_nxt = S_PV3;
      end
      S_PV3: begin
        ram_we    = 1'b1;
        ram_waddr = pivot_w[ADDR_W-1:0];
        ram_wdata = a_r;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if ((mode_r == ipu_pkg::MODE_PARTITION) ? (k_r < n_r)
                                                : (k_r != '0 && h_r != '0)) begin
          state_nxt = S_RA;
        end else begin
          split_nxt = SW'(h_r);
          e_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_RA: begin
        ram_raddr = hm1[ADDR_W-1:0];
        state_nxt = S_RC;
      end
      S_RC: begin
        ram_raddr = k_r[ADDR_W-1:0];
        a_nxt     = ram_rdata;
        state_nxt = S_RB;
      end
      S_RB: begin
        ram_raddr = h_r[ADDR_W-1:0];
        c_nxt     = ram_rdata;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        b_nxt = ram_rdata;
        if (hit) begin
          state_nxt = S_W1;
        end else begin
          k_nxt     = (mode_r == ipu_pkg::MODE_PARTITION) ? k_r + 1'b1 : k_r - 1'b1;
          state_nxt = S_LOOP;
        end
      end
      // Partition: h-1 <= c, k <= b, h <= a.  Undo: h-1 <= b, h <= c, k <= a.
      S_W1: begin
        ram_we    = 1'b1;
        ram_waddr = hm1[ADDR_W-1:0];
        ram_wdata = (mode_r == ipu_pkg::MODE_PARTITION) ? c_r : b_r;
        state_nxt = S_W2;
      end
      S_W2: begin
        ram_we    = 1'b1;
        if (mode_r == ipu_pkg::MODE_PARTITION) begin
          ram_waddr = k_r[ADDR_W-1:0];
          ram_wdata = b_r;
        end else begin
          ram_waddr = h_r[ADDR_W-1:0];
          ram_wdata = c_r;
        end
        state_nxt = S_W3;
      end
      S_W3: begin
        ram_we    = 1'b1;
        if (mode_r == ipu_pkg::MODE_PARTITION) begin
          ram_waddr = h_r[ADDR_W-1:0];
          ram_wdata = a_r;
          h_nxt     = h_r + 1'b1;
          k_nxt     = k_r + 1'b1;
        end else begin
          ram_waddr = k_r[ADDR_W-1:0];
          ram_wdata = a_r;
          h_nxt     = hm1;
          k_nxt     = k_r - 1'b1;
        end
        state_nxt = S_LOOP;
      end
      S_EMIT: begin
        ram_raddr     = e_r[ADDR_W-1:0];
        emit_vld_nxt  = 1'b1;
        emit_last_nxt = (e_r == n_r - 1'b1);
        e_nxt         = e_r + 1'b1;
        if (e_r == n_r - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      split_r    <= '0;
      emit_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      split_r    <= split_nxt;
      emit_vld_r <= emit_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    h_r         <= h_nxt;
    k_r         <= k_nxt;
    e_r         <= e_nxt;
    mode_r      <= mode_nxt;
    emit_last_r <= emit_last_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    c_r         <= c_nxt;
  end

  assign ox = ram_rdata[ENT_W-1:KEY_BITS];
  assign oy = ram_rdata[KEY_BITS-1:0];

  assign out_valid     = emit_vld_r;
  assign out_x_out     = ipu_pkg::COORD_W'(ox);
  assign out_y_out     = ipu_pkg::COORD_W'(oy);
  assign out_split_out = split_r;
  assign out_last_out  = emit_last_r;

endmodule

### sv/inplace_partition_with_undo.sv
// Top level of the in-place partition / undo block.
//
// Input channel: a beat is taken when start is high and busy is low. Each
// beat carries one (x, y) point; beats load the point store at one per
// cycle. The beat with in_last_in high also starts the operation that the
// mode register selects (partition by x around the pivot, or undo by y
// using in_split_in). Points beyond MAX_POINTS are dropped.
// Busy stays high from the last beat until the final result is issued.
// After the last beat, partition first checks the pivot and, when it names
// another loaded slot, swaps it into slot 0; then each scan step either
// only compares or compares and then does three store writes. The store
// has one write port and one registered read port, and every step goes
// through it: three reads, then up to three writes. Emit then reads the
// store at one point per cycle, so n results follow on out_valid, one per
// cycle, each after its registered store read; out_last_out marks
// the final one and out_split_out carries the final split count on every
// result.
// Results are strobed for exactly one cycle and the receiver cannot stall.
// Reset clears the control state, the point count and both registers; the
// store contents are undefined until written. Configure only while idle.
module inplace_partition_with_undo #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [ipu_pkg::PADDR_W-1:0] paddr,
  input  logic        [ipu_pkg::PDATA_W-1:0] pwdata,
  output logic        [ipu_pkg::PDATA_W-1:0] prdata,
  output logic                               pready,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ipu_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [ipu_pkg::COORD_W-1:0] in_y_coord,
  input  logic        [ipu_pkg::SPLIT_W-1:0] in_split_in,
  input  logic                               in_last_in,
  // result channel
  output logic                               out_valid,
  output logic signed [ipu_pkg::COORD_W-1:0] out_x_out,
  output logic signed [ipu_pkg::COORD_W-1:0] out_y_out,
  output logic        [ipu_pkg::SPLIT_W-1:0] out_split_out,
  output logic                               out_last_out
);

  ipu_pkg::cfg_t cfg;

  // hold mode and pivot index; the user must write them only while the block is idle (not enforced here)
  ipu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // load, scan and emit around the shared point store
  ipu_core #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .start         (start),
    .busy          (busy),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_split_in   (in_split_in),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out),
    .out_split_out (out_split_out),
    .out_last_out  (out_last_out)
  );

endmodule

### verif/ipu_checker.sv
// Checker for the in-place partition block: predicts each point set and compares the results.
module ipu_checker
  import ipu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic [SPLIT_W-1:0]        in_split_in,
  input  logic                      in_last_in,
  input  logic                      out_valid,
  input  logic signed [COORD_W-1:0] out_x_out,
  input  logic signed [COORD_W-1:0] out_y_out,
  input  logic [SPLIT_W-1:0]        out_split_out,
  input  logic                      out_last_out,
  output int unsigned               mismatch_count,
  output int unsigned               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 64;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SPLIT_W-1:0] split;
    logic               last;
  } point_beat_t;

  logic signed [COORD_W-1:0] slot_x [STORE_DEPTH];
  logic signed [COORD_W-1:0] slot_y [STORE_DEPTH];
  int unsigned               loaded;
  logic                      mode_q;
  logic [PIVOT_W-1:0]        pivot_q;
  point_beat_t               reordered_q [$];
  int unsigned               fail_tally = 0;

  assign mismatch_count = fail_tally;

  task automatic report_mismatch(string msg);
    $display("ipu_checker: %s (t=%0t)", msg, $time);
    fail_tally++;
  endtask

  function automatic void swap_slots(int unsigned p, int unsigned q);
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    tx = slot_x[p];
    ty = slot_y[p];
    slot_x[p] = slot_x[q];
    slot_y[p] = slot_y[q];
    slot_x[q] = tx;
    slot_y[q] = ty;
  endfunction

  // Lomuto-style pass: the pivot rides along at slot h-1.
  function automatic int unsigned partition_by_x(int unsigned n);
    int unsigned h;
    h = 1;
    if (32'(pivot_q) < n)
      swap_slots(0, 32'(pivot_q));
    for (int unsigned k = 1; k < n; k++) begin
      if (slot_x[k] < slot_x[h-1]) begin
        swap_slots(k, h);
        swap_slots(h - 1, h);
        h++;
      end
    end
    return h;
  endfunction

  // Backward pass that uses y as the original order key.
  function automatic int unsigned undo_by_y(int unsigned n, int unsigned split);
    int unsigned h;
    h = (split == 0) ? 0 : split - 1;
    if (h > n - 1)
      h = n - 1;
    for (int unsigned k = n - 1; k > 0; k--) begin
      if (h == 0)
        break;
      if (slot_y[h-1] > slot_y[k]) begin
        swap_slots(h - 1, h);
        swap_slots(k, h);
        h--;
      end
    end
    return h;
  endfunction

  task automatic take_point();
    int unsigned n;
    int unsigned h;
    // drop points once the store is full
    if (loaded < STORE_DEPTH) begin
      slot_x[loaded] = in_x_coord;
      slot_y[loaded] = in_y_coord;
      loaded++;
    end
    if (!in_last_in)
      return;
    n = loaded;
    if (mode_q == MODE_PARTITION)
      h = partition_by_x(n);
    else
      h = undo_by_y(n, 32'(in_split_in));
    for (int unsigned k = 0; k < n; k++)
      reordered_q.push_back({slot_x[k], slot_y[k], SPLIT_W'(h), k == n - 1});
    loaded = 0;
  endtask

  task automatic check_result();
    point_beat_t want;
    if (reordered_q.size() == 0) begin
      report_mismatch($sformatf("result x=%0d y=%0d split=%0d last=%0b %s",
                                out_x_out, out_y_out, out_split_out, out_last_out,
                                "with nothing expected"));
      return;
    end
    want = reordered_q.pop_front();
    if (out_x_out !== want.x || out_y_out !== want.y ||
        out_split_out !== want.split || out_last_out !== want.last)
      report_mismatch($sformatf({"got x=%0d y=%0d split=%0d last=%0b, ",
                                 "want x=%0d y=%0d split=%0d last=%0b"},
                                out_x_out, out_y_out, out_split_out, out_last_out,
                                $signed(want.x), $signed(want.y), want.split, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      loaded = 0;
      mode_q = MODE_PARTITION;
      pivot_q = '0;
      reordered_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1] == REG_MODE)
          mode_q = pwdata[0];
        else
          pivot_q = pwdata[PIVOT_W-1:0];
      end
      if (out_valid)
        check_result();
      if (start && !busy)
        take_point();
    end
    pending_count <= reordered_q.size();
  end

endmodule

### verif/testbench.sv
// Top of the partition/undo testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipu_pkg::*;

  localparam int ITEM_TARGET = 380;
  // slowest set is a full 64-point partition
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_PAUSE = 8;
  localparam int SETTLE      = 24;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SPLIT_W-1:0] split;
  } emitted_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic [COORD_W-1:0] in_x_coord = '0;
  logic [COORD_W-1:0] in_y_coord = '0;
  logic [SPLIT_W-1:0] in_split_in = '0;
  logic               in_last_in = 1'b0;
  logic               out_valid;
  logic [COORD_W-1:0] out_x_out;
  logic [COORD_W-1:0] out_y_out;
  logic [SPLIT_W-1:0] out_split_out;
  logic               out_last_out;

  int unsigned        mismatch_count;
  int unsigned        pending_count;
  int unsigned        items_sent = 0;
  int unsigned        idle_cycles = 0;

  // points of the set being built, and results captured for undo round trips
  logic [COORD_W-1:0] set_x [$];
  logic [COORD_W-1:0] set_y [$];
  emitted_t           emitted_q [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  inplace_partition_with_undo DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .in_x_coord   (in_x_coord),
    .in_y_coord   (in_y_coord),
    .in_split_in  (in_split_in),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_x_out    (out_x_out),
    .out_y_out    (out_y_out),
    .out_split_out(out_split_out),
    .out_last_out (out_last_out)
  );

  ipu_checker order_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .start         (start),
    .busy          (busy),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_split_in   (in_split_in),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out),
    .out_split_out (out_split_out),
    .out_last_out  (out_last_out),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // Watchdog: restart on every accepted beat, result or register write;
  // give up when the block has gone quiet for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Capture every emitted point so a partition can be fed back for undo.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      emitted_q.push_back({out_x_out, out_y_out, out_split_out});
  end

  // Gap after a beat: mostly none, some short, a few long. A burst set
  // runs with no gaps at all.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    if (burst)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Coordinates: full range, a narrow band that forces ties, or the extremes.
  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned r;
    logic [COORD_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      v = COORD_W'($urandom());
    end else if (r < 80) begin
      v = COORD_W'($urandom_range(0, 7) - 4);
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 16'h8000;
        1:       v = 16'h7fff;
        2:       v = 16'h0000;
        default: v = 16'hffff;
      endcase
    end
    return v;
  endfunction

  // Set sizes: mostly small, sometimes medium, rarely full or overfull.
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return $urandom_range(1, 8);
    if (r < 95)
      return $urandom_range(9, 24);
    return $urandom_range(64, 68);
  endfunction

  function automatic logic [PIVOT_W-1:0] pick_pivot(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return PIVOT_W'($urandom_range(0, (n > 64 ? 64 : n) - 1));
    if (r < 80)
      return PIVOT_W'($urandom_range(0, 63));
    return 6'd63;
  endfunction

  // Undo split: mostly within the set, sometimes zero, sometimes anything.
  function automatic logic [SPLIT_W-1:0] pick_split(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return SPLIT_W'($urandom_range(1, n + 1));
    if (r < 80)
      return '0;
    return SPLIT_W'($urandom_range(0, 127));
  endfunction

  // Drive one point and hold it until the block takes it. Keep start high
  // only when the next point follows in the same step.
  task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [SPLIT_W-1:0] split, logic last,
                            int unsigned gap, bit keep);
    start       <= 1'b1;
    in_x_coord  <= x;
    in_y_coord  <= y;
    in_split_in <= split;
    in_last_in  <= last;
    do @(posedge clk); while (busy);
    items_sent++;
    if (!keep || gap > 0)
      start <= 1'b0;
    // after the final beat of a set always wait with start low
    repeat ((!keep && gap == 0) ? 1 : gap) @(posedge clk);
  endtask

  task automatic add_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    set_x.push_back(x);
    set_y.push_back(y);
  endtask

  // Send the staged points as one set; split only counts on the last beat.
  task automatic send_set(logic [SPLIT_W-1:0] split_val);
    bit          burst;
    int unsigned n;
    burst = ($urandom_range(0, 3) == 0);
    n = set_x.size();
    for (int unsigned k = 0; k < n; k++)
      send_point(set_x[k], set_y[k], (k == n - 1) ? split_val : SPLIT_W'($urandom_range(0, 127)),
                 k == n - 1, pick_gap(burst), k != n - 1);
    set_x.delete();
    set_y.delete();
  endtask

  // Hold off until every expected result has come, then let the block settle.
  task automatic wait_drained();
    while (pending_count != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // One write: setup phase, access phase, then an idle phase on the bus.
  task automatic cfg_write(logic reg_sel, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram both registers on an idle block; the upper data bits carry
  // junk half the time, which the block must ignore.
  task automatic configure(logic mode_val, logic [PIVOT_W-1:0] pivot_val);
    logic [PDATA_W-1:0] junk;
    wait_drained();
    junk = $urandom_range(0, 1) ? PDATA_W'($urandom()) : '0;
    cfg_write(REG_MODE, {junk[PDATA_W-1:1], mode_val});
    cfg_write(REG_PIVOT, {junk[PDATA_W-1:PIVOT_W], pivot_val});
  endtask

  // Partition a set whose y keys rise with position, then feed the block's
  // own output and split count back through undo.
  task automatic round_trip();
    int unsigned        n;
    int                 base;
    int                 step;
    logic [SPLIT_W-1:0] h;
    n = $urandom_range(2, 24);
    configure(MODE_PARTITION, pick_pivot(n));
    emitted_q.delete();
    base = $urandom_range(0, 20000) - 32768;
    step = $urandom_range(1, 500);
    for (int unsigned k = 0; k < n; k++)
      add_point(pick_coord(), COORD_W'(base + k * step));
    send_set(SPLIT_W'($urandom_range(0, 127)));
    configure(MODE_UNDO, pick_pivot(n));
    h = emitted_q[0].split;
    foreach (emitted_q[k])
      add_point(emitted_q[k].x, emitted_q[k].y);
    send_set(h);
  endtask

  initial begin
    int unsigned n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a single point at the coordinate extremes, reset registers.
    add_point(16'h8000, 16'h7fff);
    send_set(7'd1);

    // Partition around a mid pivot, with ties and both extremes of x.
    configure(MODE_PARTITION, 6'd2);
    add_point(16'd3, 16'h8000);
    add_point(16'h8000, 16'h7fff);
    add_point(16'h7fff, 16'd0);
    add_point(16'd3, 16'hffff);
    add_point(16'd0, 16'd5);
    send_set(7'd0);

    // Pivot beyond the set: slot zero stays the pivot.
    configure(MODE_PARTITION, 6'd63);
    add_point(16'd5, 16'd1);
    add_point(16'd1, 16'd2);
    add_point(16'd9, 16'd3);
    send_set(7'd127);

    // Undo with an ordinary split.
    configure(MODE_UNDO, 6'd0);
    add_point(16'd10, 16'd4);
    add_point(16'd20, 16'hffff);
    add_point(16'd30, 16'd7);
    add_point(16'd40, 16'd2);
    send_set(7'd3);

    // Undo with a split of zero: nothing moves.
    add_point(16'd1, 16'd9);
    add_point(16'd2, 16'd1);
    send_set(7'd0);

    // Undo with the widest split: saturate to the last slot.
    add_point(16'h7fff, 16'd3);
    add_point(16'h8000, 16'h8000);
    add_point(16'd0, 16'h7fff);
    add_point(16'hffff, 16'd0);
    send_set(7'd127);

    // Undo with a split of one: starts at slot zero and stops at once.
    add_point(16'd7, 16'd8);
    add_point(16'd6, 16'd2);
    send_set(7'd1);

    // Random: one overfull set first, so the drop path is always hit.
    configure(1'($urandom_range(0, 1)), pick_pivot(64));
    for (int unsigned k = 0; k < 66; k++)
      add_point(pick_coord(), pick_coord());
    send_set(pick_split(64));

    // Then a mix of partition/undo round trips and free-form sets.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 30) begin
        round_trip();
      end else begin
        n = pick_size();
        if ($urandom_range(0, 2) == 0)
          configure(1'($urandom_range(0, 1)), pick_pivot(n));
        for (int unsigned k = 0; k < n; k++)
          add_point(pick_coord(), pick_coord());
        send_set(pick_split(n));
      end
    end

    // Drain, let stray results show up, then give the verdict.
    while (pending_count != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
sv/ipu_pkg.sv
sv/ipu_ram.sv
sv/ipu_cfg.sv
sv/ipu_core.sv
sv/inplace_partition_with_undo.sv
verif/ipu_checker.sv
verif/testbench.sv
